>>> hw/rtl/imu_fifo_frame_parser_calibrator_defines.svh
// Assertion macros used by the checker of the IMU frame parser.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef IMU_FIFO_FRAME_PARSER_CALIBRATOR_DEFINES_SVH
`define IMU_FIFO_FRAME_PARSER_CALIBRATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IMU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imu check failed");

// Consequent must hold in the cycle after the antecedent.
`define IMU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imu check failed");

`endif

>>> hw/rtl/imu_pkg.sv
package imu_pkg;

  // Frame headers and batch limit.
  localparam logic [7:0] ACCEL_HEADER = 8'd132;
  localparam logic [7:0] GYRO_HEADER  = 8'd136;
  localparam logic [8:0] MAX_FRAMES   = 9'd256;

  // Number of payload bytes held before the closing byte arrives.
  localparam logic [2:0] HELD_BYTES = 3'd5;

  localparam int DIFF_W = 25;
  localparam int PROD_W = 43;

  localparam logic KIND_ACCEL = 1'b0;
  localparam logic KIND_GYRO  = 1'b1;

  typedef enum logic [2:0] {
    REG_RANGE     = 3'd0,
    REG_AXIS_MODE = 3'd1,
    REG_OFFSET_X  = 3'd2,
    REG_OFFSET_Y  = 3'd3,
    REG_OFFSET_Z  = 3'd4,
    REG_GAIN_X    = 3'd5,
    REG_GAIN_Y    = 3'd6,
    REG_GAIN_Z    = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_ACCEL = 2'd1,
    PH_GYRO  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic [1:0]         range_select;
    logic [7:0]         axis_mode;
    logic signed [23:0] offset_x;
    logic signed [23:0] offset_y;
    logic signed [23:0] offset_z;
    logic signed [17:0] gain_x;
    logic signed [17:0] gain_y;
    logic signed [17:0] gain_z;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       batch_start;
    logic [8:0] max_frames;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  index;
    logic        three;
    axis_t       x_axis;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
    logic [15:0] raw_z;
  } frame_t;

  typedef struct packed {
    logic                     kind;
    logic [7:0]               index;
    logic                     three;
    axis_t                    x_axis;
    logic signed [DIFF_W-1:0] diff_x;
    logic signed [DIFF_W-1:0] diff_y;
    logic signed [DIFF_W-1:0] diff_z;
  } cal_t;

  typedef struct packed {
    logic               frame_kind;
    logic [7:0]         frame_index;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
  } result_t;

endpackage

>>> hw/rtl/imu_cfg.sv
module imu_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [2:0]    wr_index,
  input  logic [23:0]   wr_data,
  output imu_pkg::cfg_t cfg_o
);
  import imu_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_select <= 2'd2;
      cfg_r.axis_mode    <= 8'd85;
      cfg_r.offset_x     <= '0;
      cfg_r.offset_y     <= '0;
      cfg_r.offset_z     <= '0;
      cfg_r.gain_x       <= 18'sd16384;
      cfg_r.gain_y       <= 18'sd16384;
      cfg_r.gain_z       <= 18'sd16384;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_RANGE:     cfg_r.range_select <= wr_data[1:0];
        REG_AXIS_MODE: cfg_r.axis_mode    <= wr_data[7:0];
        REG_OFFSET_X:  cfg_r.offset_x     <= $signed(wr_data);
        REG_OFFSET_Y:  cfg_r.offset_y     <= $signed(wr_data);
        REG_OFFSET_Z:  cfg_r.offset_z     <= $signed(wr_data);
        REG_GAIN_X:    cfg_r.gain_x       <= $signed(wr_data[17:0]);
        REG_GAIN_Y:    cfg_r.gain_y       <= $signed(wr_data[17:0]);
        REG_GAIN_Z:    cfg_r.gain_z       <= $signed(wr_data[17:0]);
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

>>> hw/rtl/imu_parse.sv
module imu_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  imu_pkg::in_item_t item,
  input  logic              advance,
  input  logic [7:0]        axis_mode,
  output logic              frame_valid,
  output imu_pkg::frame_t   frame
);
  import imu_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [2:0] count_r, count_nxt;
  logic [8:0] done_r, done_nxt;
  logic [8:0] limit_r, limit_nxt;
  logic [7:0] bytes_r [HELD_BYTES];

  phase_t     phase_eff;
  logic [2:0] count_eff;
  logic [8:0] done_eff;
  logic [8:0] limit_eff;
  logic [8:0] limit_in;
  logic       active;
  logic       store;
  logic       emit;
  logic       step;
  logic       frame_valid_r;
  frame_t     frame_r, frame_nxt;
  axis_t      sel_axis;
  logic [15:0] rx, ry, rz;

  // A batch start clears the parser before its own byte is looked at.
  assign limit_in  = (item.max_frames > MAX_FRAMES) ? MAX_FRAMES : item.max_frames;
  assign phase_eff = item.batch_start ? PH_HUNT : phase_r;
  assign count_eff = item.batch_start ? 3'd0 : count_r;
  assign done_eff  = item.batch_start ? 9'd0 : done_r;
  assign limit_eff = item.batch_start ? limit_in : limit_r;
  assign active    = done_eff < limit_eff;
  assign step      = item_valid && advance;

  // Next state.
  always_comb begin
    phase_nxt = phase_eff;
    count_nxt = count_eff;
    done_nxt  = done_eff;
    limit_nxt = limit_eff;
    store     = 1'b0;
    if (active) begin
      unique case (phase_eff)
        PH_HUNT: begin
          count_nxt = 3'd0;
          if (item.data_byte == ACCEL_HEADER) begin
            phase_nxt = PH_ACCEL;
          end else if (item.data_byte == GYRO_HEADER) begin
            phase_nxt = PH_GYRO;
          end
        end
        PH_ACCEL, PH_GYRO: begin
          if (count_eff < HELD_BYTES) begin
            store     = 1'b1;
            count_nxt = count_eff + 3'd1;
          end else begin
            phase_nxt = PH_HUNT;
            count_nxt = 3'd0;
            if (phase_eff == PH_ACCEL || axis_mode[3]) begin
              done_nxt = done_eff + 9'd1;
            end
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          count_nxt = 3'd0;
        end
      endcase
    end
  end

  // Outputs: frame assembly on the closing byte.
  always_comb begin
    rx = {bytes_r[1], bytes_r[0]};
    ry = {bytes_r[3], bytes_r[2]};
    rz = {item.data_byte, bytes_r[4]};
    emit = active && (phase_eff == PH_ACCEL || (phase_eff == PH_GYRO && axis_mode[3]))
           && (count_eff >= HELD_BYTES);
    frame_nxt.index = done_eff[7:0];
    frame_nxt.raw_y = ry;
    frame_nxt.raw_z = rz;
    if (phase_eff == PH_ACCEL) begin
      frame_nxt.kind  = KIND_ACCEL;
      frame_nxt.three = axis_mode[0];
      case (axis_mode[2:1])
        2'd0:    sel_axis = AX_X;
        2'd1:    sel_axis = AX_Y;
        default: sel_axis = AX_Z;
      endcase
    end else begin
      frame_nxt.kind  = KIND_GYRO;
      frame_nxt.three = axis_mode[4];
      case (axis_mode[7:5]) inside
        3'd0, 3'd3: sel_axis = AX_X;
        3'd1, 3'd4: sel_axis = AX_Y;
        default:    sel_axis = AX_Z;
      endcase
    end
    if (frame_nxt.three) begin
      sel_axis = AX_X;
    end
    frame_nxt.x_axis = sel_axis;
    case (sel_axis)
      AX_X:    frame_nxt.raw_x = rx;
      AX_Y:    frame_nxt.raw_x = ry;
      default: frame_nxt.raw_x = rz;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      count_r       <= 3'd0;
      done_r        <= 9'd0;
      limit_r       <= 9'd0;
      frame_valid_r <= 1'b0;
    end else begin
      if (step) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        done_r  <= done_nxt;
        limit_r <= limit_nxt;
      end
      if (advance) begin
        frame_valid_r <= item_valid && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && store) begin
      bytes_r[count_eff] <= item.data_byte;
    end
    if (step && emit) begin
      frame_r <= frame_nxt;
    end
  end

  assign frame_valid = frame_valid_r;
  assign frame       = frame_r;

endmodule

>>> hw/rtl/imu_cal.sv
module imu_cal (
  input  logic             clk,
  input  logic             rst_n,
  input  imu_pkg::cfg_t    cfg,
  input  logic             frame_valid,
  input  imu_pkg::frame_t  frame,
  input  logic             adv_diff,
  input  logic             adv_out,
  output logic             diff_valid,
  output logic             res_valid,
  output imu_pkg::result_t res
);
  import imu_pkg::*;

  logic    diff_valid_r;
  logic    res_valid_r;
  cal_t    cal_r, cal_nxt;
  result_t res_r, res_nxt;
  logic signed [23:0] off_sel;
  logic signed [17:0] gain_sel;

  // Scale the raw count to Q.16 g and take the offset off.
  function automatic logic signed [DIFF_W-1:0] scale_diff(
    input logic [15:0]        raw,
    input logic signed [23:0] off,
    input logic [1:0]         rng
  );
    logic signed [20:0] scaled;
    scaled = 21'($signed(raw)) <<< ({1'b0, rng} + 3'd2);
    return DIFF_W'(scaled) - DIFF_W'(off);
  endfunction

  // Q.14 gain, round half up. |diff| < 2^24 and |gain| <= 2^17, so the
  // result stays below 2^27 and can never reach the 32-bit limits.
  function automatic logic signed [31:0] apply_gain(
    input logic signed [DIFF_W-1:0] diff,
    input logic signed [17:0]       gain
  );
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W:0]   rounded;
    prod    = diff * gain;
    rounded = (PROD_W+1)'(prod) + (PROD_W+1)'(8192);
    return 32'($signed(rounded[PROD_W:14]));
  endfunction

  always_comb begin
    case (frame.x_axis)
      AX_X:    off_sel = cfg.offset_x;
      AX_Y:    off_sel = cfg.offset_y;
      default: off_sel = cfg.offset_z;
    endcase
    cal_nxt.kind   = frame.kind;
    cal_nxt.index  = frame.index;
    cal_nxt.three  = frame.three;
    cal_nxt.x_axis = frame.x_axis;
    if (frame.kind == KIND_GYRO) begin
      cal_nxt.diff_x = DIFF_W'($signed(frame.raw_x));
      cal_nxt.diff_y = DIFF_W'($signed(frame.raw_y));
      cal_nxt.diff_z = DIFF_W'($signed(frame.raw_z));
    end else begin
      cal_nxt.diff_x = scale_diff(frame.raw_x, off_sel, cfg.range_select);
      cal_nxt.diff_y = scale_diff(frame.raw_y, cfg.offset_y, cfg.range_select);
      cal_nxt.diff_z = scale_diff(frame.raw_z, cfg.offset_z, cfg.range_select);
    end
  end

  always_comb begin
    case (cal_r.x_axis)
      AX_X:    gain_sel = cfg.gain_x;
      AX_Y:    gain_sel = cfg.gain_y;
      default: gain_sel = cfg.gain_z;
    endcase
    res_nxt.frame_kind  = cal_r.kind;
    res_nxt.frame_index = cal_r.index;
    if (cal_r.kind == KIND_GYRO) begin
      res_nxt.value_x = 32'(cal_r.diff_x);
      res_nxt.value_y = 32'(cal_r.diff_y);
      res_nxt.value_z = 32'(cal_r.diff_z);
    end else begin
      res_nxt.value_x = apply_gain(cal_r.diff_x, gain_sel);
      res_nxt.value_y = apply_gain(cal_r.diff_y, cfg.gain_y);
      res_nxt.value_z = apply_gain(cal_r.diff_z, cfg.gain_z);
    end
    if (!cal_r.three) begin
      res_nxt.value_y = '0;
      res_nxt.value_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      if (adv_diff) begin
        diff_valid_r <= frame_valid;
      end
      if (adv_out) begin
        res_valid_r <= diff_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_diff && frame_valid) begin
      cal_r <= cal_nxt;
    end
    if (adv_out && diff_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign diff_valid = diff_valid_r;
  assign res_valid  = res_valid_r;
  assign res        = res_r;

endmodule

>>> hw/rtl/imu_fifo_frame_parser_calibrator.sv
// IMU FIFO frame parser and accelerometer calibrator. The block takes the
// sensor FIFO stream one byte per beat, at a sustained rate of one byte every
// clock cycle unless the output stalls, and offers a result beat once the byte
// closing a frame has passed the input, frame, offset and output registers.
// It hunts for an accel or gyro header byte, gathers the six little-endian
// payload bytes of the frame and then emits one result (none for a gyro frame
// while gyro is off in axis_mode bit 3, or once the frame limit is reached):
// accel frames are shifted to Q.16 g by the full-scale setting, have the axis
// offset removed and are multiplied by the Q.14 axis gain with round-half-up;
// gyro frames carry their raw counts. Each of the three axis lanes owns one
// 25x18 multiplier, and that multiply is what sets the stage depth. A beat
// with batch start set clears the parser and frame count and loads the frame
// limit (clamped to 256) before its own byte is parsed; nothing is emitted
// before the first batch. Configuration registers may only be written while
// the block holds no item in flight.
module imu_fifo_frame_parser_calibrator (
  input  logic         clk,
  input  logic         rst_n,
  // Byte stream from the sensor FIFO.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // [7:0] data_byte, [16:8] max_frames, rest zero
  input  logic [0:0]   in_tuser,   // [0] batch_start
  // Calibrated frames.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // [7:0] frame_index, [39:8] value_x,
                                   // [71:40] value_y, [103:72] value_z
  output logic [0:0]   out_tuser,  // [0] frame_kind
  // Register writes.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data
);
  import imu_pkg::*;

  cfg_t     cfg;
  in_item_t item_r;
  logic     item_valid_r;
  logic     frame_valid;
  frame_t   frame;
  logic     diff_valid;
  logic     res_valid;
  result_t  res;
  logic     adv_in, adv_frame, adv_diff, adv_out;

  // Register writes are always taken; they are only legal while idle.
  assign cfg_ready = 1'b1;

  imu_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg_o    (cfg)
  );

  // Each stage moves on when it is empty or when the stage after it moves,
  // so bubbles close up and a waiting result only holds the input back once
  // every stage behind it is full.
  assign adv_out   = !res_valid || out_tready;
  assign adv_diff  = !diff_valid || adv_out;
  assign adv_frame = !frame_valid || adv_diff;
  assign adv_in    = !item_valid_r || adv_frame;
  assign in_tready = adv_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (adv_in) begin
      item_valid_r <= in_tvalid;
    end
  end

  // Input register: byte plus batch controls.
  always_ff @(posedge clk) begin
    if (adv_in && in_tvalid) begin
      item_r.data_byte   <= in_tdata[7:0];
      item_r.max_frames  <= in_tdata[16:8];
      item_r.batch_start <= in_tuser[0];
    end
  end

  imu_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid_r),
    .item        (item_r),
    .advance     (adv_frame),
    .axis_mode   (cfg.axis_mode),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  imu_cal u_cal (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .frame_valid (frame_valid),
    .frame       (frame),
    .adv_diff    (adv_diff),
    .adv_out     (adv_out),
    .diff_valid  (diff_valid),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign out_tvalid   = res_valid;
  assign out_tdata    = {res.value_z, res.value_y, res.value_x, res.frame_index};
  assign out_tuser[0] = res.frame_kind;

endmodule

>>> hw/rtl/imu_chk.sv
`include "imu_fifo_frame_parser_calibrator_defines.svh"

module imu_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic [0:0]   out_tuser
);

  // A result waiting for the sink holds still.
  `IMU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // No result straight after reset: the pipeline is empty.
  `IMU_ASSERT_SAME(a_reset_empty, !$past(rst_n), !out_tvalid)

  // Calibrated accel values stay within +/-2^27, so bits 31..27 agree.
  `IMU_ASSERT_SAME(a_accel_range, out_tvalid && !out_tuser[0], (out_tdata[39:35] == 5'h1f) || (out_tdata[39:35] == 5'h00))

  // Gyro values are sign-extended 16-bit counts.
  `IMU_ASSERT_SAME(a_gyro_sext, out_tvalid && out_tuser[0], (out_tdata[39:23] == 17'h1ffff) || (out_tdata[39:23] == 17'h00000))

endmodule

bind imu_fifo_frame_parser_calibrator imu_chk u_chk (.*);

>>> test/imu_fifo_frame_parser_calibrator_tb.sv
`timescale 1ns / 100ps

import imu_pkg::*;

// Tracks the parser state and the register set alongside the block and holds
// the frames it should emit, oldest first.
class frame_scoreboard;
  cfg_t        cfg;
  phase_t      phase;
  logic [2:0]  held;
  logic [7:0]  payload [5];
  int unsigned frames_done;
  int unsigned frames_limit;
  result_t     expected_frames [$];
  int unsigned mismatches;

  function new();
    cfg.range_select = 2'd2;
    cfg.axis_mode    = 8'd85;
    cfg.offset_x     = '0;
    cfg.offset_y     = '0;
    cfg.offset_z     = '0;
    cfg.gain_x       = 18'sd16384;
    cfg.gain_y       = 18'sd16384;
    cfg.gain_z       = 18'sd16384;
    phase            = PH_HUNT;
    held             = '0;
    frames_done      = 0;
    frames_limit     = 0;
    mismatches       = 0;
    foreach (payload[i]) payload[i] = '0;
  endfunction

  function void apply_reg(reg_idx_t idx, logic [23:0] v);
    case (idx)
      REG_RANGE:     cfg.range_select = v[1:0];
      REG_AXIS_MODE: cfg.axis_mode    = v[7:0];
      REG_OFFSET_X:  cfg.offset_x     = v;
      REG_OFFSET_Y:  cfg.offset_y     = v;
      REG_OFFSET_Z:  cfg.offset_z     = v;
      REG_GAIN_X:    cfg.gain_x       = v[17:0];
      REG_GAIN_Y:    cfg.gain_y       = v[17:0];
      REG_GAIN_Z:    cfg.gain_z       = v[17:0];
      default: ;
    endcase
  endfunction

  // Shift to Q.16 g, remove the offset, apply the Q.14 gain with
  // round-half-up, then clamp to 32 bits.
  function logic signed [31:0] calibrate(logic signed [15:0] raw,
                                         logic signed [23:0] offset,
                                         logic signed [17:0] gain);
    longint scaled, diff, prod, r;
    scaled = longint'(raw) * (longint'(1) << (cfg.range_select + 2));
    diff   = scaled - longint'(offset);
    prod   = diff * longint'(gain);
    r      = (prod + 64'sd8192) >>> 14;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // Steps the parser by one accepted byte and queues any frame it closes.
  function void note_byte(logic [7:0] b, logic start, logic [8:0] max_frames);
    logic signed [15:0] raw_x, raw_y, raw_z;
    logic signed [31:0] vx, vy, vz;
    logic               gyro_frame, three;
    axis_t              sel;
    result_t            frame;
    if (start) begin
      frames_limit = (max_frames > MAX_FRAMES) ? MAX_FRAMES : max_frames;
      frames_done  = 0;
      phase        = PH_HUNT;
      held         = '0;
    end
    if (frames_done >= frames_limit) return;
    if (phase == PH_HUNT) begin
      if (b == ACCEL_HEADER) begin
        phase = PH_ACCEL;
        held  = '0;
      end else if (b == GYRO_HEADER) begin
        phase = PH_GYRO;
        held  = '0;
      end
      return;
    end
    if (held < HELD_BYTES) begin
      payload[held] = b;
      held++;
      return;
    end
    raw_x      = {payload[1], payload[0]};
    raw_y      = {payload[3], payload[2]};
    raw_z      = {b, payload[4]};
    gyro_frame = (phase == PH_GYRO);
    phase      = PH_HUNT;
    held       = '0;
    if (!gyro_frame) begin
      vx    = calibrate(raw_x, cfg.offset_x, cfg.gain_x);
      vy    = calibrate(raw_y, cfg.offset_y, cfg.gain_y);
      vz    = calibrate(raw_z, cfg.offset_z, cfg.gain_z);
      three = cfg.axis_mode[0];
      sel   = axis_t'(cfg.axis_mode[2:1]);
    end else begin
      // A disabled gyro frame is swallowed and does not count.
      if (!cfg.axis_mode[3]) return;
      vx    = raw_x;
      vy    = raw_y;
      vz    = raw_z;
      three = cfg.axis_mode[4];
      sel   = (cfg.axis_mode[7:5] > 3'd5) ? AX_Z : axis_t'(cfg.axis_mode[7:5] % 3'd3);
    end
    frame            = '0;
    frame.frame_kind = gyro_frame ? KIND_GYRO : KIND_ACCEL;
    frame.frame_index = frames_done[7:0];
    if (three) begin
      frame.value_x = vx;
      frame.value_y = vy;
      frame.value_z = vz;
    end else begin
      case (sel)
        AX_X:    frame.value_x = vx;
        AX_Y:    frame.value_x = vy;
        default: frame.value_x = vz;
      endcase
    end
    frames_done++;
    expected_frames.push_back(frame);
  endfunction

  function void compare_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function void check_frame(logic kind, logic [7:0] index, logic signed [31:0] vx,
                            logic signed [31:0] vy, logic signed [31:0] vz);
    result_t want;
    if (expected_frames.size() == 0) begin
      mismatches++;
      $display("%0t: frame beat with none expected, kind %0d index %0d", $time, kind, index);
      return;
    end
    want = expected_frames.pop_front();
    compare_field("frame_kind", want.frame_kind, kind);
    compare_field("frame_index", want.frame_index, index);
    compare_field("value_x", want.value_x, vx);
    compare_field("value_y", want.value_y, vy);
    compare_field("value_z", want.value_z, vz);
  endfunction

  function int unsigned pending();
    return expected_frames.size();
  endfunction
endclass

module imu_fifo_frame_parser_calibrator_tb;

  // The settle pause leaves a comfortable margin for the closing byte of a
  // frame to pass the input, frame, offset and output registers.
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SEG_ITEMS     = 128;
  localparam int unsigned SEGMENTS      = 12;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [23:0]  in_tdata   = '0;
  logic [0:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index  = '0;
  logic [23:0]  cfg_data   = '0;

  // Idle rates in percent per cycle, set by the stimulus process.
  int unsigned in_idle_pct  = 8;
  int unsigned out_idle_pct = 52;
  // Raised once by the stimulus; the receiver then stalls on its own count.
  bit          hold_wanted  = 1'b0;
  int unsigned cycles       = 0;

  frame_scoreboard sb;

  imu_fifo_frame_parser_calibrator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Watchdog: a correct run finishes far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d frames outstanding", $time, sb.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver. It stalls at random, and once on request holds off for a long
  // stretch so that the pipeline backs up into the byte input.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_wanted && !hold_done && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  // Values are sampled at the edge, before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_frame(out_tuser[0], out_tdata[7:0], out_tdata[39:8],
                     out_tdata[71:40], out_tdata[103:72]);
    end
  end

  // Offers one byte, with random idle cycles ahead of it, and returns once
  // the beat has been taken.
  task automatic send_byte(input logic [7:0] b, input logic start,
                           input logic [8:0] lim);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, lim, b};
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b, start, lim);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [23:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_reg(idx, v);
  endtask

  // Waits for every outstanding frame, then lets the pipeline empty of
  // bytes that made no frame.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Batch limits: mostly short batches, with the edges of the field mixed in.
  function automatic logic [8:0] rand_limit();
    case ($urandom_range(0, 19))
      0:       return 9'd0;
      1:       return MAX_FRAMES;
      2:       return 9'($urandom_range(257, 511));
      3:       return 9'($urandom_range(0, 255));
      default: return 9'($urandom_range(1, 16));
    endcase
  endfunction

  // Payload bytes lean towards the sign and magnitude extremes now and then.
  function automatic logic [7:0] rand_payload();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_header();
    return ($urandom_range(0, 9) < 6) ? ACCEL_HEADER : GYRO_HEADER;
  endfunction

  // Header followed by a number of payload bytes; sent counts the bytes
  // offered.
  task automatic send_frame_bytes(input logic [7:0] hdr, input int unsigned count,
                                  inout int unsigned sent);
    send_byte(hdr, 1'b0, 9'($urandom));
    sent++;
    repeat (count) begin
      send_byte(rand_payload(), 1'b0, 9'($urandom));
      sent++;
    end
  endtask

  // Mostly complete frames; the rest is batch restarts, loose bytes and
  // frames cut short by a new batch.
  task automatic run_stream(input int unsigned n);
    int unsigned sent;
    int unsigned pick;
    logic [7:0]  b;
    sent = 0;
    send_byte(rand_header(), 1'b1, rand_limit());
    sent++;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        b = $urandom_range(0, 1) ? rand_header() : 8'($urandom);
        send_byte(b, 1'b1, rand_limit());
        sent++;
      end else if (pick < 80) begin
        send_frame_bytes(rand_header(), 6, sent);
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 3)) begin
          send_byte(8'($urandom), 1'b0, 9'($urandom));
          sent++;
        end
      end else begin
        send_frame_bytes(rand_header(), $urandom_range(0, 5), sent);
        send_byte(rand_header(), 1'b1, rand_limit());
        sent++;
      end
    end
  endtask

  // Axis modes chosen so that, over the run, every accel and gyro axis
  // selection is seen, both three-axis modes, and gyro both on and off.
  function automatic logic [7:0] axis_for(int unsigned seg);
    case (seg)
      1:       return 8'h08;
      2:       return 8'hFF;
      3:       return 8'h0A;
      4:       return 8'h2C;
      5:       return 8'h4E;
      6:       return 8'h68;
      7:       return 8'h88;
      8:       return 8'hA9;
      9:       return 8'hC8;
      10:      return 8'hE8;
      11:      return 8'h00;
      default: return 8'h55;
    endcase
  endfunction

  function automatic logic [23:0] rand_offset();
    case ($urandom_range(0, 3))
      0:       return 24'(int'($urandom_range(0, 2047)) - 1024);
      1:       return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_gain();
    case ($urandom_range(0, 3))
      0:       return 24'd16384;
      1:       return $urandom_range(0, 1) ? 24'h01FFFF : 24'h020000;
      default: return 24'($urandom);
    endcase
  endfunction

  // Segment one takes the offsets and gains to their tops with the smallest
  // full scale, segment two to their bottoms with the largest; the others
  // are random.
  task automatic configure(input int unsigned seg);
    logic [1:0] range_sel;
    range_sel = (seg == 1) ? 2'd0 : (seg == 2) ? 2'd3 : 2'($urandom_range(0, 3));
    write_reg(REG_RANGE, {22'd0, range_sel});
    write_reg(REG_AXIS_MODE, {16'd0, axis_for(seg)});
    if (seg == 1) begin
      write_reg(REG_OFFSET_X, 24'h7FFFFF);
      write_reg(REG_OFFSET_Y, 24'h7FFFFF);
      write_reg(REG_OFFSET_Z, 24'h7FFFFF);
      write_reg(REG_GAIN_X, 24'h01FFFF);
      write_reg(REG_GAIN_Y, 24'h01FFFF);
      write_reg(REG_GAIN_Z, 24'h01FFFF);
    end else if (seg == 2) begin
      write_reg(REG_OFFSET_X, 24'h800000);
      write_reg(REG_OFFSET_Y, 24'h800000);
      write_reg(REG_OFFSET_Z, 24'h800000);
      write_reg(REG_GAIN_X, 24'h020000);
      write_reg(REG_GAIN_Y, 24'h020000);
      write_reg(REG_GAIN_Z, 24'h020000);
    end else begin
      write_reg(REG_OFFSET_X, rand_offset());
      write_reg(REG_OFFSET_Y, rand_offset());
      write_reg(REG_OFFSET_Z, rand_offset());
      write_reg(REG_GAIN_X, rand_gain());
      write_reg(REG_GAIN_Y, rand_gain());
      write_reg(REG_GAIN_Z, rand_gain());
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned seg;
    logic [7:0]  payload_lo [6];
    logic [7:0]  payload_hi [6];
    payload_lo = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h80};
    payload_hi = '{8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF};
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, under the reset register values (accel three-axis,
    // gyro off). A header before any batch must be ignored.
    send_byte(ACCEL_HEADER, 1'b0, 9'd5);
    // One-frame batch carrying the most negative and most positive counts.
    send_byte(ACCEL_HEADER, 1'b1, 9'd1);
    foreach (payload_lo[i]) send_byte(payload_lo[i], 1'b0, 9'd0);
    // The limit is reached, so this header goes nowhere.
    send_byte(ACCEL_HEADER, 1'b0, 9'd0);
    // An oversized limit is clamped; the gyro frame is swallowed while off.
    send_byte(GYRO_HEADER, 1'b1, 9'd511);
    foreach (payload_hi[i]) send_byte(payload_hi[i], 1'b0, 9'd0);
    // A frame cut short by a new batch is dropped; a zero limit blocks all.
    send_byte(ACCEL_HEADER, 1'b0, 9'd0);
    send_byte(8'h12, 1'b0, 9'd0);
    send_byte(8'h34, 1'b0, 9'd0);
    send_byte(8'h55, 1'b1, 9'd0);
    // Full-size batch opened by a byte that is itself the header.
    send_byte(ACCEL_HEADER, 1'b1, MAX_FRAMES);
    foreach (payload_hi[i]) send_byte(payload_hi[i], 1'b0, 9'd0);

    // Random part: four segments with a slow receiver, four with a slow
    // sender, four at full rate. Registers change between segments only.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg != 0) begin
        drain();
        configure(seg);
      end
      if (seg < 4) begin
        in_idle_pct  = 8;
        out_idle_pct = 52;
      end else if (seg < 8) begin
        in_idle_pct  = 52;
        out_idle_pct = 8;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if (seg == 8) hold_wanted = 1'b1;
      run_stream(SEG_ITEMS);
    end
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      if (sb.pending() != 0) $display("%0t: %0d frames never arrived", $time, sb.pending());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/imu_pkg.sv
hw/rtl/imu_cfg.sv
hw/rtl/imu_parse.sv
hw/rtl/imu_cal.sv
hw/rtl/imu_fifo_frame_parser_calibrator.sv
hw/rtl/imu_chk.sv
test/imu_fifo_frame_parser_calibrator_tb.sv
